// File: design/cel_pkg.sv
// Shared types and constants for the cross-entropy loss and accuracy block.
package cel_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int POS_W = 4;
    localparam int CNT_W = 7;
    localparam int LSUM_W = 26;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [LSUM_W-1:0] LSUM_MAX = {LSUM_W{1'b1}};
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [15:0] prob;
        logic [3:0]  true_label;
        logic        last_in_row;
        logic        last_in_batch;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] grad;
        logic [23:0]        mean_loss;
        logic [16:0]        accuracy;
        logic               batch_done;
    } out_item_t;

    // Work handed from the front to the back for one element.
    typedef struct packed {
        logic        is_true;
        logic [15:0] prob;
        logic        end_batch;
        logic [LSUM_W-1:0] loss_base;
        logic [CNT_W-1:0]  rows;
        logic [CNT_W-1:0]  correct;
    } job_t;

endpackage

// File: design/cel_front.sv
// Front end: argmax, row and batch tracking, counters; issues one job per element.
module cel_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cel_pkg::in_item_t in_item,
    input  logic              loss_add_valid,
    input  logic [cel_pkg::LSUM_W-1:0] loss_add,
    output logic              job_valid,
    input  logic              job_ready,
    output cel_pkg::job_t     job
);
    import cel_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [15:0]       best_val_reg;
    logic [POS_W-1:0]  best_cls_reg;
    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  corr_reg;
    logic [LSUM_W-1:0] lsum_reg;
    logic              wait_reg;

    logic [POS_W-1:0] best_cls_now;
    logic             end_row;
    logic             is_true;
    logic             acc;
    logic [LSUM_W:0]  sum_wide;

    // A true-class element must have its loss folded in before the next one.
    assign full = wait_reg || !job_ready;
    assign acc = push && !full;
    assign is_true = (pos_reg == in_item.true_label);
    assign end_row = in_item.last_in_row || in_item.last_in_batch
                     || (pos_reg == POS_W'(MAX_CLASSES - 1));

    always_comb
    begin
        best_cls_now = best_cls_reg;
        if (pos_reg == '0 || in_item.prob > best_val_reg)
            best_cls_now = pos_reg;
    end

    assign sum_wide = {1'b0, lsum_reg} + {1'b0, loss_add};

    always_comb
    begin
        job.is_true   = is_true;
        job.prob      = in_item.prob;
        job.end_batch = in_item.last_in_batch;
        job.loss_base = lsum_reg;
        job.rows      = (end_row && rows_reg != CNT_MAX) ? rows_reg + 1'b1 : rows_reg;
        job.correct   = (end_row && best_cls_now == in_item.true_label
                         && corr_reg != CNT_MAX) ? corr_reg + 1'b1 : corr_reg;
    end
    assign job_valid = acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            best_val_reg <= '0;
            best_cls_reg <= '0;
            rows_reg     <= '0;
            corr_reg     <= '0;
            lsum_reg     <= '0;
            wait_reg     <= 1'b0;
        end
        else
        begin
            if (loss_add_valid)
            begin
                wait_reg <= 1'b0;
                lsum_reg <= sum_wide[LSUM_W] ? LSUM_MAX : sum_wide[LSUM_W-1:0];
            end
            if (acc)
            begin
                if (pos_reg == '0 || in_item.prob > best_val_reg)
                    best_val_reg <= in_item.prob;
                best_cls_reg <= best_cls_now;
                pos_reg  <= end_row ? '0 : pos_reg + 1'b1;
                rows_reg <= job.rows;
                corr_reg <= job.correct;
                if (is_true && !in_item.last_in_batch)
                    wait_reg <= 1'b1;
                if (in_item.last_in_batch)
                begin
                    pos_reg      <= '0;
                    best_val_reg <= '0;
                    best_cls_reg <= '0;
                    rows_reg     <= '0;
                    corr_reg     <= '0;
                    lsum_reg     <= '0;
                end
            end
        end
    end

endmodule

// File: design/cel_queue.sv
// Short job queue between front and back.
module cel_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  cel_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output cel_pkg::job_t rd_data
);
    import cel_pkg::*;

    job_t mem_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != ($clog2(QDEPTH)+1)'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end

endmodule

// File: design/cel_back.sv
// Back end: log, gradient divide and batch-end divides, one sequencer.
module cel_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [6:0]         batch_rows,
    input  logic               job_valid,
    output logic               job_ready,
    input  cel_pkg::job_t      job,
    output logic               loss_add_valid,
    output logic [cel_pkg::LSUM_W-1:0] loss_add,
    output logic               empty,
    input  logic               pop,
    output cel_pkg::out_item_t out_item
);
    import cel_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOG  = 3'd1;
    localparam logic [2:0] S_LN   = 3'd2;
    localparam logic [2:0] S_GDIV = 3'd3;
    localparam logic [2:0] S_MDIV = 3'd4;
    localparam logic [2:0] S_ADIV = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  st_reg;
    job_t        job_reg;
    logic [4:0]  it_reg;
    logic [3:0]  e_reg;
    logic [16:0] m_reg;
    logic [15:0] frac_reg;
    logic [LSUM_W-1:0] loss_reg;
    logic [22:0] den_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic signed [31:0] grad_reg;
    logic [23:0] mean_reg;
    out_item_t   obuf_reg;
    logic        ofull_reg;

    logic [15:0] kc;
    logic [3:0]  e_det;
    logic [33:0] msq;
    logic [16:0] msq_s;
    logic [19:0] l2;
    logic [51:0] lnprod;
    logic [32:0] gtrial;
    logic [32:0] dtrial;
    logic [LSUM_W:0] tsum;
    logic [CNT_W-1:0] rdiv;

    assign kc = (job_reg.prob == 16'd0) ? 16'd1 :
                (job_reg.prob > 16'd32767) ? 16'd32767 : job_reg.prob;

    always_comb
    begin
        e_det = '0;
        for (int i = 1; i < 15; i++)
            if (kc[i])
                e_det = 4'(i);
    end

    // dividend 2^31 has its only set bit in the first step
    assign msq   = 34'(m_reg) * 34'(m_reg);
    assign msq_s = msq[31:15];
    assign l2    = (20'd15 << 16) - {e_reg, frac_reg};
    assign lnprod = 52'(l2) * 52'(LN2_Q32);
    assign gtrial = {rem_reg, (it_reg == 5'd0)} - {10'd0, den_reg};
    assign dtrial = {rem_reg, quo_reg[31]} - {26'd0, dvs_reg};
    assign tsum  = {1'b0, job_reg.loss_base} + {1'b0, loss_reg};
    assign rdiv  = (job_reg.rows == '0) ? CNT_W'(1) : job_reg.rows;

    assign job_ready = (st_reg == S_IDLE);
    assign empty = !ofull_reg;
    assign out_item = obuf_reg;

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg  <= job;
                    loss_reg <= '0;
                    grad_reg <= '0;
                    mean_reg <= '0;
                end
            end
            S_LOG:
            begin
                if (it_reg == 5'd0)
                begin
                    e_reg    <= e_det;
                    m_reg    <= 17'(kc << (4'd15 - e_det));
                    frac_reg <= '0;
                end
                else
                begin
                    frac_reg <= {frac_reg[14:0], msq_s[16]};
                    m_reg    <= msq_s[16] ? {1'b0, msq_s[16:1]} : msq_s;
                end
            end
            S_LN:
            begin
                loss_reg <= LSUM_W'(lnprod[51:32]);
                den_reg  <= 23'(batch_rows) * 23'(job_reg.prob);
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            S_GDIV:
            begin
                if (den_reg == '0)
                    grad_reg <= 32'sh8000_0000;
                else
                begin
                    // quotient bit 31 - it of 2^31 / den
                    if (!gtrial[32])
                    begin
                        rem_reg <= gtrial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], (it_reg == 5'd0)};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    if (it_reg == 5'd31)
                        grad_reg <= -$signed(gtrial[32] ? {quo_reg[30:0], 1'b0}
                                                        : {quo_reg[30:0], 1'b1});
                end
            end
            S_MDIV, S_ADIV:
            begin
                if (it_reg == 5'd0)
                begin
                    // dividend top bit is always zero, so it is pre-shifted
                    dvs_reg   <= rdiv;
                    rem_reg   <= '0;
                    quo_reg   <= (st_reg == S_MDIV)
                        ? {5'd0, (tsum[LSUM_W] ? LSUM_MAX : tsum[LSUM_W-1:0]), 1'b0}
                        : {8'd0, job_reg.correct, 17'd0};
                end
                else
                begin
                    if (!dtrial[32])
                    begin
                        rem_reg <= dtrial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[30:0], quo_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (st_reg == S_OUT && (!ofull_reg || pop))
        begin
            obuf_reg.grad       <= grad_reg;
            obuf_reg.mean_loss  <= job_reg.end_batch ? mean_reg : '0;
            obuf_reg.accuracy   <= job_reg.end_batch
                ? ((quo_reg > 32'd65536) ? 17'd65536 : quo_reg[16:0]) : '0;
            obuf_reg.batch_done <= job_reg.end_batch;
        end
        if (st_reg == S_ADIV && it_reg == 5'd0)
            mean_reg <= (quo_reg > 32'hFF_FFFF) ? 24'hFF_FFFF : quo_reg[23:0];
    end

    // restoring division: rem takes the next dividend bit each step

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            it_reg         <= '0;
            ofull_reg      <= 1'b0;
            loss_add_valid <= 1'b0;
            loss_add       <= '0;
        end
        else
        begin
            loss_add_valid <= 1'b0;
            if (ofull_reg && pop)
                ofull_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    it_reg <= '0;
                    if (job_valid)
                        st_reg <= job.is_true ? S_LOG : (job.end_batch ? S_MDIV : S_OUT);
                end
                S_LOG:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 5'd16)
                        st_reg <= S_LN;
                end
                S_LN:
                begin
                    it_reg <= '0;
                    st_reg <= S_GDIV;
                    if (!job_reg.end_batch)
                    begin
                        loss_add_valid <= 1'b1;
                        loss_add       <= LSUM_W'(lnprod[51:32]);
                    end
                end
                S_GDIV:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (den_reg == '0 || it_reg == 5'd31)
                    begin
                        it_reg <= '0;
                        st_reg <= job_reg.end_batch ? S_MDIV : S_OUT;
                    end
                end
                S_MDIV:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 5'd31)
                    begin
                        it_reg <= '0;
                        st_reg <= S_ADIV;
                    end
                end
                S_ADIV:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 5'd31)
                    begin
                        it_reg <= '0;
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ofull_reg || pop)
                    begin
                        ofull_reg <= 1'b1;
                        st_reg    <= S_IDLE;
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/cross_entropy_loss_accuracy.sv
// Top level of the cross-entropy loss, gradient and accuracy block.
// Path: a true-class element takes a 17-step log and a 32-step gradient divide
// on its way to the output; a batch-end element adds the mean-loss and accuracy
// divides. The back-end sequencer takes one job at a time, only when idle, and
// the front stalls after a true-class element until its loss is folded in.
// Reset: asynchronous, active low; batch_rows returns to 1, counters clear.
module cross_entropy_loss_accuracy
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cel_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output cel_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data
);
    import cel_pkg::*;

    logic [6:0] batch_rows_reg;
    logic       fj_valid, fj_ready, bj_valid, bj_ready;
    job_t       fj, bj;
    logic       la_valid;
    logic [LSUM_W-1:0] la;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            batch_rows_reg <= 7'd1;
        else if (cfg_valid && cfg_ready)
            batch_rows_reg <= cfg_data;
    end

    cel_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .loss_add_valid(la_valid), .loss_add(la),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    cel_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready),
        .wr_data(fj), .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    cel_back u_back
    (
        .clk(clk), .rst_n(rst_n), .batch_rows(batch_rows_reg),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .loss_add_valid(la_valid), .loss_add(la),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    a_batch_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !out_item.batch_done |-> out_item.mean_loss == '0)
        else $error("mean_loss outside batch end");
    a_grad_sign: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(out_item.grad > 0))
        else $error("positive gradient");
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> out_item.accuracy <= 17'd65536)
        else $error("accuracy out of range");

endmodule
